/* sv/lpr_pkg.sv */
package lpr_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 10;

	// pen color width (rgb565)
	localparam int COLOR_BITS = 16;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [0:0] REG_DRAW_COLOR = 1'b0;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// two-bit step directions, two's complement
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

endpackage

/* sv/lpr_if.sv */
// command channel: load or step items
interface lpr_cmd_if #(
	parameter int CW = 10
);
	logic          valid;
	logic          ready;
	logic          mode;
	logic [CW-1:0] x_start;
	logic [CW-1:0] y_start;
	logic [CW-1:0] x_end;
	logic [CW-1:0] y_end;

	modport source (output valid, output mode, output x_start, output y_start,
		output x_end, output y_end, input ready);
	modport sink (input valid, input mode, input x_start, input y_start,
		input x_end, input y_end, output ready);
endinterface

// pixel channel: one rasterized pixel per transfer
interface lpr_pix_if import lpr_pkg::*; #(
	parameter int CW = 10
);
	logic                  valid;
	logic                  ready;
	logic [CW-1:0]         pixel_x;
	logic [CW-1:0]         pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
		output last_pixel, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
		input last_pixel, output ready);
endinterface

/* sv/lpr_front.sv */
module lpr_front import lpr_pkg::*; #(
	parameter int  CW = COORD_BITS_DEF,
	parameter type cmd_t = logic
) (
	lpr_cmd_if.sink cmd,
	input  logic    q_full,
	output logic    q_push,
	output cmd_t    q_data
);

	logic [CW-1:0] adx;
	logic [CW-1:0] ady;
	logic [1:0]    dcol;
	logic [1:0]    drow;

	// accept whenever the queue has room
	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	// column delta and direction
	always_comb begin
		if (cmd.x_end > cmd.x_start) begin
			adx  = cmd.x_end - cmd.x_start;
			dcol = DIR_POS;
		end else if (cmd.x_end < cmd.x_start) begin
			adx  = cmd.x_start - cmd.x_end;
			dcol = DIR_NEG;
		end else begin
			adx  = '0;
			dcol = DIR_NONE;
		end
	end

	// row delta and direction
	always_comb begin
		if (cmd.y_end > cmd.y_start) begin
			ady  = cmd.y_end - cmd.y_start;
			drow = DIR_POS;
		end else if (cmd.y_end < cmd.y_start) begin
			ady  = cmd.y_start - cmd.y_end;
			drow = DIR_NEG;
		end else begin
			ady  = '0;
			drow = DIR_NONE;
		end
	end

	// classified command for the back end
	always_comb begin
		q_data.mode  = cmd.mode;
		q_data.x0    = cmd.x_start;
		q_data.y0    = cmd.y_start;
		q_data.adx   = adx;
		q_data.ady   = ady;
		q_data.dcol  = dcol;
		q_data.drow  = drow;
		q_data.major = (adx > ady) ? adx : ady;
	end

endmodule

/* sv/lpr_queue.sv */
module lpr_queue import lpr_pkg::*; #(
	parameter int  DEPTH = QUEUE_DEPTH_DEF,
	parameter type cmd_t = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_data,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output cmd_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [NW-1:0] FULL_CNT  = NW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/lpr_back.sv */
module lpr_back import lpr_pkg::*; #(
	parameter int  CW = COORD_BITS_DEF,
	parameter type cmd_t = logic
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COLOR_BITS-1:0] color,
	input  logic                  q_valid,
	input  cmd_t                  q_data,
	output logic                  q_pop,
	lpr_pix_if.source             pix
);

	localparam int EW = CW + 2;
	localparam int LW = CW + 1;

	logic [CW-1:0] cur_col_q;
	logic [CW-1:0] cur_row_q;
	logic [EW-1:0] err_col_q;
	logic [EW-1:0] err_row_q;
	logic [CW-1:0] abs_dx_q;
	logic [CW-1:0] abs_dy_q;
	logic [1:0]    dir_col_q;
	logic [1:0]    dir_row_q;
	logic [CW-1:0] major_q;
	logic [LW-1:0] left_q;
	logic          active_q;

	logic                  out_valid_q;
	logic [CW-1:0]         out_x_q;
	logic [CW-1:0]         out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic                  out_last_q;

	logic          slot_free;
	logic          is_load;
	logic          emit;
	logic          last;
	logic [EW-1:0] col_sum;
	logic [EW-1:0] row_sum;
	logic          col_hit;
	logic          row_hit;
	logic [EW-1:0] err_col_nxt;
	logic [EW-1:0] err_row_nxt;
	logic [CW-1:0] cur_col_nxt;
	logic [CW-1:0] cur_row_nxt;

	// move a coordinate one step, wrapping
	function automatic logic [CW-1:0] step_coord(input logic [CW-1:0] pos,
		input logic [1:0] dir);
		logic [CW-1:0] res;
		case (dir)
			DIR_POS: res = pos + 1'b1;
			DIR_NEG: res = pos - 1'b1;
			default: res = pos;
		endcase
		return res;
	endfunction

	// pop when the output register can take a pixel
	assign slot_free = !out_valid_q || pix.ready;
	assign q_pop     = q_valid && slot_free;
	assign is_load   = (q_data.mode == MODE_LOAD);
	assign emit      = q_pop && !is_load && active_q;
	assign last      = (left_q <= LW'(1));

	// error accumulation on both axes
	always_comb begin
		col_sum     = err_col_q + {2'b00, abs_dx_q};
		row_sum     = err_row_q + {2'b00, abs_dy_q};
		col_hit     = (col_sum > {2'b00, major_q});
		row_hit     = (row_sum > {2'b00, major_q});
		err_col_nxt = col_hit ? col_sum - {2'b00, major_q} : col_sum;
		err_row_nxt = row_hit ? row_sum - {2'b00, major_q} : row_sum;
		cur_col_nxt = col_hit ? step_coord(cur_col_q, dir_col_q) : cur_col_q;
		cur_row_nxt = row_hit ? step_coord(cur_row_q, dir_row_q) : cur_row_q;
	end

	// line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= emit;
			end
			if (q_pop && is_load) begin
				active_q <= 1'b1;
				left_q   <= {1'b0, q_data.major} + LW'(2);
			end else if (emit) begin
				if (last) begin
					active_q <= 1'b0;
					left_q   <= '0;
				end else begin
					left_q <= left_q - 1'b1;
				end
			end
		end
	end

	// line datapath
	always_ff @(posedge clk) begin
		if (q_pop && is_load) begin
			cur_col_q <= q_data.x0;
			cur_row_q <= q_data.y0;
			err_col_q <= '0;
			err_row_q <= '0;
			abs_dx_q  <= q_data.adx;
			abs_dy_q  <= q_data.ady;
			dir_col_q <= q_data.dcol;
			dir_row_q <= q_data.drow;
			major_q   <= q_data.major;
		end else if (emit) begin
			cur_col_q <= cur_col_nxt;
			cur_row_q <= cur_row_nxt;
			err_col_q <= err_col_nxt;
			err_row_q <= err_row_nxt;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= cur_col_q;
			out_y_q     <= cur_row_q;
			out_color_q <= color;
			out_last_q  <= last;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_y     = out_y_q;
	assign pix.pixel_color = out_color_q;
	assign pix.last_pixel  = out_last_q;

endmodule

/* sv/line_pixel_rasterizer.sv */
// Line rasterizer: a load command (mode 0) latches two endpoints and emits nothing; each
// step command (mode 1) emits one pixel in the pen color while a line is active, and a
// line of major length n gives n+2 pixels (start point twice, last one flagged). Steps
// with no active line give nothing. While neither side stalls, the block takes one command
// per clock and delivers one pixel per clock. A step command is registered in a command
// queue entry and its pixel in the pixel output register before the pixel transfer.
// The back end does one error add, compare and subtract per axis for each pixel in
// combinational logic; the two-entry command queue in front of it and the pixel output
// register decouple the two sides, so a pixel stall holds up commands only once the queue
// fills. cmd.ready drops only when the queue is full. The pen color is at byte address 0
// of the register port and is sampled when a pixel is produced.
module line_pixel_rasterizer import lpr_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lpr_cmd_if.sink                  cmd,
	lpr_pix_if.source                pix,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	typedef struct packed {
		logic                  mode;
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] adx;
		logic [COORD_BITS-1:0] ady;
		logic [1:0]            dcol;
		logic [1:0]            drow;
		logic [COORD_BITS-1:0] major;
	} lpr_cmd_t;

	logic [COLOR_BITS-1:0] color_q;
	logic                  cfg_wr;
	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	lpr_cmd_t              q_wr_data;
	lpr_cmd_t              q_rd_data;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DRAW_COLOR);
	assign prdata = (paddr[2] == REG_DRAW_COLOR) ?
		{{(APB_DATA_BITS-COLOR_BITS){1'b0}}, color_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg_wr) begin
			color_q <= pwdata[COLOR_BITS-1:0];
		end
	end

	lpr_front #(
		.CW    (COORD_BITS),
		.cmd_t (lpr_cmd_t)
	) u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr_data)
	);

	lpr_queue #(
		.DEPTH (QUEUE_DEPTH),
		.cmd_t (lpr_cmd_t)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	lpr_back #(
		.CW    (COORD_BITS),
		.cmd_t (lpr_cmd_t)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.color   (color_q),
		.q_valid (q_valid),
		.q_data  (q_rd_data),
		.q_pop   (q_pop),
		.pix     (pix)
	);

`ifndef SYNTHESIS
	// input stalls only when the queue holds commands
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> q_valid)
		else $error("command stalled with empty queue");

	// a new pixel only follows a queue pop
	a_pix_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix.valid) |-> $past(q_pop))
		else $error("pixel appeared without a queue pop");

	// pen color write lands next cycle
	a_color_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (color_q == $past(pwdata[COLOR_BITS-1:0])))
		else $error("pen color write lost");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import lpr_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int EW = CW + 2;
	localparam int LW = CW + 1;
	localparam int COORD_MAX = (1 << CW) - 1;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_DRAW_COLOR = APB_ADDR_BITS'({REG_DRAW_COLOR, 2'b00});
	localparam logic [APB_ADDR_BITS-1:0] ADDR_SPARE = APB_ADDR_BITS'(4);
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CONFIG_EVERY = 300;

	typedef struct packed {
		logic [CW-1:0]         x;
		logic [CW-1:0]         y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	lpr_cmd_if #(.CW(CW)) cmd ();
	lpr_pix_if #(.CW(CW)) pix ();

	line_pixel_rasterizer #(.COORD_BITS(CW)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.pix     (pix),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// expected pixels and bookkeeping
	pixel_t pixel_q[$];
	int     err_count;
	int     cmd_count;
	bit     quiet_phase;

	// shadow of the rasterizer state
	logic [COLOR_BITS-1:0] pen_color;
	logic [CW-1:0]         cur_col;
	logic [CW-1:0]         cur_row;
	logic [EW-1:0]         err_col;
	logic [EW-1:0]         err_row;
	logic [CW-1:0]         abs_dx;
	logic [CW-1:0]         abs_dy;
	logic [1:0]            dir_col;
	logic [1:0]            dir_row;
	logic [CW-1:0]         major_len;
	logic [LW-1:0]         pixels_left;
	logic                  line_active;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial begin
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

	// delta and direction of one axis
	function automatic void axis_setup(input logic [CW-1:0] from, input logic [CW-1:0] to,
		output logic [CW-1:0] delta, output logic [1:0] dir);
		if (to > from) begin
			dir = DIR_POS;
			delta = to - from;
		end else if (to < from) begin
			dir = DIR_NEG;
			delta = from - to;
		end else begin
			dir = DIR_NONE;
			delta = '0;
		end
	endfunction

	// error accumulate on one axis, step the coordinate on overflow
	function automatic void axis_advance(inout logic [EW-1:0] err, input logic [CW-1:0] delta,
		inout logic [CW-1:0] pos, input logic [1:0] dir);
		logic [EW-1:0] sum;
		sum = err + EW'(delta);
		if (sum > EW'(major_len)) begin
			sum = sum - EW'(major_len);
			if (dir == DIR_POS)
				pos = pos + 1'b1;
			else if (dir == DIR_NEG)
				pos = pos - 1'b1;
		end
		err = sum;
	endfunction

	// predict the effect of one accepted command
	task automatic rasterize_cmd(input logic m, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
		input logic [CW-1:0] xe, input logic [CW-1:0] ye);
		pixel_t px;
		if (m == MODE_LOAD) begin
			axis_setup(xs, xe, abs_dx, dir_col);
			axis_setup(ys, ye, abs_dy, dir_row);
			major_len = (abs_dx > abs_dy) ? abs_dx : abs_dy;
			cur_col = xs;
			cur_row = ys;
			err_col = '0;
			err_row = '0;
			pixels_left = LW'(major_len) + LW'(2);
			line_active = 1'b1;
		end else if (line_active) begin
			px.x = cur_col;
			px.y = cur_row;
			px.color = pen_color;
			px.last = (pixels_left <= 1);
			pixel_q.push_back(px);
			axis_advance(err_col, abs_dx, cur_col, dir_col);
			axis_advance(err_row, abs_dy, cur_row, dir_row);
			if (pixels_left <= 1) begin
				pixels_left = '0;
				line_active = 1'b0;
			end else begin
				pixels_left = pixels_left - 1'b1;
			end
		end
	endtask

	// one command transfer after a random gap
	task automatic send_cmd(input logic m, input logic [CW-1:0] xs, input logic [CW-1:0] ys,
		input logic [CW-1:0] xe, input logic [CW-1:0] ye);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.mode <= m;
		cmd.x_start <= xs;
		cmd.y_start <= ys;
		cmd.x_end <= xe;
		cmd.y_end <= ye;
		do @(posedge clk); while (!cmd.ready);
		if (m == MODE_LOAD || line_active)
			cmd_count++;
		rasterize_cmd(m, xs, ys, xe, ye);
	endtask

	// load a line, then issue step commands with junk endpoints
	task automatic send_line(input logic [CW-1:0] xs, input logic [CW-1:0] ys,
		input logic [CW-1:0] xe, input logic [CW-1:0] ye, input int steps);
		send_cmd(MODE_LOAD, xs, ys, xe, ye);
		repeat (steps)
			send_cmd(MODE_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	// stop sending and wait for every expected pixel, then for a drain margin
	task automatic drain_pixels();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write or read, reads of the pen color are checked
	task automatic apb_access(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
		input logic [APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr && addr == ADDR_DRAW_COLOR)
			pen_color = data[COLOR_BITS-1:0];
		if (!wr && addr == ADDR_DRAW_COLOR && prdata[COLOR_BITS-1:0] !== pen_color) begin
			$display("%0t draw_color read mismatch: expected %h actual %h",
				$time, pen_color, prdata[COLOR_BITS-1:0]);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return CW'(COORD_MAX);
		return CW'(v);
	endfunction

	// one random sequence: mostly well-formed lines, some noise
	task automatic send_random_sequence();
		int kind;
		int reach;
		int off;
		int dx;
		int dy;
		int major;
		int pick;
		int steps;
		logic [CW-1:0] xs;
		logic [CW-1:0] ys;
		logic [CW-1:0] xe;
		logic [CW-1:0] ye;
		kind = $urandom_range(0, 99);
		quiet_phase = ($urandom_range(0, 7) == 0);
		xs = CW'($urandom);
		ys = CW'($urandom);
		if (kind < 10) begin
			send_cmd(1'($urandom_range(0, 1)), xs, ys, CW'($urandom), CW'($urandom));
		end else begin
			if (kind == 10) begin
				xe = CW'($urandom);
				ye = CW'($urandom);
			end else begin
				reach = $urandom_range(0, 16);
				off = int'($urandom_range(0, 2 * reach)) - reach;
				xe = clamp_coord(int'(xs) + off);
				off = int'($urandom_range(0, 2 * reach)) - reach;
				ye = clamp_coord(int'(ys) + off);
			end
			dx = int'(xe) - int'(xs);
			dy = int'(ye) - int'(ys);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			major = (dx > dy) ? dx : dy;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				steps = major + 2;
			else if (pick < 9)
				steps = $urandom_range(1, major + 1);
			else
				steps = major + 2 + $urandom_range(1, 3);
			// long lines are mostly cut short by the next load
			if (kind == 10 && pick >= 4)
				steps = $urandom_range(1, 40);
			send_line(xs, ys, xe, ye, steps);
		end
	endtask

	// steps with no line give nothing, color reads back as reset value
	task automatic test_idle_steps();
		apb_access(1'b0, ADDR_DRAW_COLOR, '0);
		send_cmd(MODE_STEP, CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX));
		send_cmd(MODE_STEP, '0, '0, '0, '0);
		drain_pixels();
	endtask

	// corner endpoints, reload while active, zero length line
	task automatic test_directed_lines();
		apb_access(1'b1, ADDR_DRAW_COLOR, APB_DATA_BITS'(16'hFFFF));
		send_line('0, '0, CW'(COORD_MAX), CW'(COORD_MAX), 3);
		send_line(CW'(COORD_MAX), CW'(COORD_MAX), '0, '0, 3);
		send_line(CW'(COORD_MAX), '0, '0, CW'(COORD_MAX), 2);
		send_line(CW'(512), CW'(512), CW'(512), CW'(512), 3);
		send_line(CW'(5), CW'(5), CW'(8), CW'(6), 6);
		drain_pixels();
	endtask

	// random lines with color changes between phases
	task automatic test_random_lines();
		int start;
		int next_cfg;
		int cfg_idx;
		logic [APB_DATA_BITS-1:0] color_word;
		start = cmd_count;
		next_cfg = start;
		cfg_idx = 0;
		while (cmd_count < start + RANDOM_ITEMS) begin
			if (cmd_count >= next_cfg) begin
				drain_pixels();
				case (cfg_idx)
					0: color_word = '0;
					1: color_word = APB_DATA_BITS'(16'hFFFF);
					default: color_word = $urandom;
				endcase
				apb_access(1'b1, ADDR_DRAW_COLOR, color_word);
				// writes past the last register must leave the color alone
				apb_access(1'b1, ADDR_SPARE, $urandom);
				apb_access(1'b0, ADDR_DRAW_COLOR, '0);
				cfg_idx++;
				next_cfg = next_cfg + CONFIG_EVERY;
			end
			// occasional full pause until all pixels are out
			if ($urandom_range(0, 49) == 0)
				drain_pixels();
			send_random_sequence();
		end
		drain_pixels();
	endtask

	// pixel sink with random stalls
	initial begin
		int gap;
		pix.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			gap = quiet_phase ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				pix.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pix.ready <= 1'b1;
			do @(posedge clk); while (!pix.valid);
		end
	end

	// compare each pixel transfer against the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n === 1'b1 && pix.valid && pix.ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t unexpected pixel: expected none actual x=%0d y=%0d color=%h last=%b",
					$time, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				if (pix.pixel_x !== want.x) begin
					$display("%0t pixel_x mismatch: expected %0d actual %0d",
						$time, want.x, pix.pixel_x);
					err_count++;
				end
				if (pix.pixel_y !== want.y) begin
					$display("%0t pixel_y mismatch: expected %0d actual %0d",
						$time, want.y, pix.pixel_y);
					err_count++;
				end
				if (pix.pixel_color !== want.color) begin
					$display("%0t pixel_color mismatch: expected %h actual %h",
						$time, want.color, pix.pixel_color);
					err_count++;
				end
				if (pix.last_pixel !== want.last) begin
					$display("%0t last_pixel mismatch: expected %b actual %b",
						$time, want.last, pix.last_pixel);
					err_count++;
				end
			end
		end
	end

	// reset, then the tests in turn
	initial begin
		err_count = 0;
		cmd_count = 0;
		quiet_phase = 1'b0;
		pen_color = '0;
		cur_col = '0;
		cur_row = '0;
		err_col = '0;
		err_row = '0;
		abs_dx = '0;
		abs_dy = '0;
		dir_col = DIR_NONE;
		dir_row = DIR_NONE;
		major_len = '0;
		pixels_left = '0;
		line_active = 1'b0;
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.mode <= MODE_LOAD;
		cmd.x_start <= '0;
		cmd.y_start <= '0;
		cmd.x_end <= '0;
		cmd.y_end <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_steps();
		test_directed_lines();
		test_random_lines();
		drain_pixels();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
